>>> rtl/pru_pkg.sv
// Shared types and constants for the pixel replication upscaler.
// Used by pixel_replication_upscaler_top; depends on nothing.
package pru_pkg;

  localparam int COLOR_W    = 8;
  localparam int RGB_W      = 3 * COLOR_W;
  localparam int SCALE_W    = 5;
  localparam int WIDTH_W    = 13;
  localparam int CFG_DATA_W = 13;
  localparam int ROWS_W     = 4;
  localparam int COPY_W     = 4;
  localparam int PADC_W     = 2;

  typedef enum logic [0:0] {
    FUNC_PUSH = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_PAD    = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [0:0] {
    CFG_SCALE        = 1'b0,
    CFG_SOURCE_WIDTH = 1'b1
  } cfg_reg_e;

endpackage

>>> rtl/pixel_replication_upscaler_top.sv
// Pixel replication upscaler: line store, drain counters and result emitter.
// Depends on pru_pkg.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   func_i, red_i, green_i, blue_i
//   out      source     out_valid_o / out_stall_i kind_o, out_red/green/blue_o,
//                                                 row_end_o, last_o
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A tick can follow the previous request at once; its pixel is read from the
// single-port line store into a read register that loads with the job register.
// A push gives scale results, plus pad results when it closes a row (up to 19 with
// MAX_SCALE at 16): the emitter puts out one result per cycle from its job register
// while the output is not stalled, and the input stalls until the last one is taken.
// A rejected push gives a single reject result; an idle tick gives nothing.
// Reset clears all counters and the job/output valid bits; the store needs no clear.
// An output stall holds the output register, then the job register, then the input.
module pixel_replication_upscaler_top #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_SCALE = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic [pru_pkg::COLOR_W-1:0]       red_i,
  input  logic [pru_pkg::COLOR_W-1:0]       green_i,
  input  logic [pru_pkg::COLOR_W-1:0]       blue_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        kind_o,
  output logic [pru_pkg::COLOR_W-1:0]       out_red_o,
  output logic [pru_pkg::COLOR_W-1:0]       out_green_o,
  output logic [pru_pkg::COLOR_W-1:0]       out_blue_o,
  output logic                              row_end_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_index_i,
  input  logic [pru_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int DW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (DW > pru_pkg::WIDTH_W) ? DW : pru_pkg::WIDTH_W;
  localparam int CW = WW + 1;
  localparam int NW = pru_pkg::SCALE_W + 1;
  localparam int PADC_W_L = pru_pkg::PADC_W;

  typedef enum logic [1:0] {
    JOB_PUSH,
    JOB_REJECT,
    JOB_TICK_PIX,
    JOB_TICK_PAD
  } job_e;

  // configuration
  logic [pru_pkg::SCALE_W-1:0] scale_q;
  logic [pru_pkg::WIDTH_W-1:0] source_width_q;

  // drain state
  logic [AW-1:0]                fill_col_q, fill_col_d;
  logic [pru_pkg::ROWS_W-1:0]   rows_left_q, rows_left_d;
  logic [DW-1:0]                drain_col_q, drain_col_d;
  logic [pru_pkg::COPY_W-1:0]   copy_cnt_q, copy_cnt_d;
  logic [pru_pkg::PADC_W-1:0]   pad_cnt_q, pad_cnt_d;

  // line store
  logic [pru_pkg::RGB_W-1:0]    line_mem [MAX_WIDTH];
  logic [pru_pkg::RGB_W-1:0]    rd_data_q;
  logic                         mem_we, mem_re;

  // job register
  logic                         job_valid_q;
  job_e                         job_type_q, job_type_d;
  logic [pru_pkg::RGB_W-1:0]    job_rgb_q;
  logic [pru_pkg::SCALE_W-1:0]  job_s_q;
  logic [PADC_W_L-1:0]          job_pad_q;
  logic                         job_row_done_q;
  logic                         job_end_q, job_end_d;
  logic [NW-1:0]                job_cnt_q;
  logic                         job_load;

  // output register
  logic                         out_valid_q;
  logic [1:0]                   out_kind_q;
  logic [pru_pkg::RGB_W-1:0]    out_rgb_q;
  logic                         out_row_end_q;
  logic                         out_last_q;

  logic                         in_acc;
  logic                         is_push;
  logic                         busy;
  logic [pru_pkg::SCALE_W-1:0]  s_eff;
  logic [WW-1:0]                w_eff;
  logic [PADC_W_L-1:0]          pad;
  logic [3:0]                   pad_prod;
  logic                         row_done;
  logic [pru_pkg::RGB_W-1:0]    in_rgb;

  logic                         out_load;
  logic [NW-1:0]                job_n;
  logic [NW-1:0]                cnt_nxt;
  logic                         res_last;
  logic [1:0]                   res_kind;
  logic [pru_pkg::RGB_W-1:0]    res_rgb;
  logic                         res_row_end;
  logic                         job_done;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q        <= pru_pkg::SCALE_W'(1);
      source_width_q <= pru_pkg::WIDTH_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (pru_pkg::cfg_reg_e'(cfg_index_i))
        pru_pkg::CFG_SCALE:        scale_q        <= cfg_data_i[pru_pkg::SCALE_W-1:0];
        pru_pkg::CFG_SOURCE_WIDTH: source_width_q <= cfg_data_i[pru_pkg::WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (scale_q == '0) begin
      s_eff = pru_pkg::SCALE_W'(1);
    end else if (32'(scale_q) > MAX_SCALE) begin
      s_eff = pru_pkg::SCALE_W'(MAX_SCALE);
    end else begin
      s_eff = scale_q;
    end
    if (source_width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(source_width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(source_width_q);
    end
  end

  // 3*w*s bytes need (w*s) mod 4 pad bytes; only the low bits matter
  assign pad_prod = w_eff[1:0] * s_eff[1:0];
  assign pad      = pad_prod[1:0];

  // ---------------------------------------------------------------- accept
  assign in_stall_o = job_valid_q && !job_done;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_push    = (pru_pkg::func_e'(func_i) == pru_pkg::FUNC_PUSH);
  assign busy       = (rows_left_q != '0);
  assign in_rgb     = {red_i, green_i, blue_i};
  assign row_done   = (CW'(fill_col_q) + CW'(1)) >= CW'(w_eff);

  always_comb begin
    fill_col_d  = fill_col_q;
    rows_left_d = rows_left_q;
    drain_col_d = drain_col_q;
    copy_cnt_d  = copy_cnt_q;
    pad_cnt_d   = pad_cnt_q;
    job_load    = 1'b0;
    job_type_d  = JOB_REJECT;
    job_end_d   = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    if (in_acc) begin
      if (is_push) begin
        job_load = 1'b1;
        if (busy) begin
          job_type_d = JOB_REJECT;
        end else begin
          job_type_d = JOB_PUSH;
          mem_we     = 1'b1;
          if (row_done) begin
            fill_col_d  = '0;
            rows_left_d = pru_pkg::ROWS_W'(s_eff - pru_pkg::SCALE_W'(1));
            drain_col_d = '0;
            copy_cnt_d  = '0;
            pad_cnt_d   = '0;
          end else begin
            fill_col_d = fill_col_q + AW'(1);
          end
        end
      end else if (busy) begin
        job_load = 1'b1;
        if (CW'(drain_col_q) < CW'(w_eff)) begin
          job_type_d = JOB_TICK_PIX;
          mem_re     = 1'b1;
          if ((NW'(copy_cnt_q) + NW'(1)) >= NW'(s_eff)) begin
            copy_cnt_d  = '0;
            drain_col_d = drain_col_q + DW'(1);
            job_end_d   = ((CW'(drain_col_q) + CW'(1)) >= CW'(w_eff)) && (pad == '0);
          end else begin
            copy_cnt_d = copy_cnt_q + pru_pkg::COPY_W'(1);
          end
        end else begin
          job_type_d = JOB_TICK_PAD;
          job_end_d  = ({1'b0, pad_cnt_q} + 3'd1) >= {1'b0, pad};
          if (!job_end_d) begin
            pad_cnt_d = pad_cnt_q + PADC_W_L'(1);
          end
        end
        // close the drained row
        if (job_end_d) begin
          drain_col_d = '0;
          copy_cnt_d  = '0;
          pad_cnt_d   = '0;
          rows_left_d = rows_left_q - pru_pkg::ROWS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_col_q  <= '0;
      rows_left_q <= '0;
      drain_col_q <= '0;
      copy_cnt_q  <= '0;
      pad_cnt_q   <= '0;
    end else begin
      fill_col_q  <= fill_col_d;
      rows_left_q <= rows_left_d;
      drain_col_q <= drain_col_d;
      copy_cnt_q  <= copy_cnt_d;
      pad_cnt_q   <= pad_cnt_d;
    end
  end

  // ---------------------------------------------------------------- line store
  // Read data holds until the next tick read, which cannot come before its job leaves.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[fill_col_q] <= in_rgb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= line_mem[drain_col_q[AW-1:0]];
    end
  end

  // ---------------------------------------------------------------- emitter
  assign out_load = !out_valid_q || !out_stall_i;
  assign job_n    = NW'(job_s_q) + (job_row_done_q ? NW'(job_pad_q) : NW'(0));
  assign cnt_nxt  = job_cnt_q + NW'(1);

  always_comb begin
    res_kind    = pru_pkg::KIND_REJECT;
    res_rgb     = '0;
    res_row_end = 1'b0;
    res_last    = 1'b1;
    case (job_type_q)
      JOB_PUSH: begin
        res_last = (cnt_nxt == job_n);
        if (job_cnt_q < NW'(job_s_q)) begin
          res_kind    = pru_pkg::KIND_PIXEL;
          res_rgb     = job_rgb_q;
          res_row_end = job_row_done_q && (job_pad_q == '0) && (cnt_nxt == NW'(job_s_q));
        end else begin
          res_kind    = pru_pkg::KIND_PAD;
          res_row_end = (cnt_nxt == job_n);
        end
      end
      JOB_REJECT: begin
        res_kind = pru_pkg::KIND_REJECT;
      end
      JOB_TICK_PIX: begin
        res_kind    = pru_pkg::KIND_PIXEL;
        res_rgb     = rd_data_q;
        res_row_end = job_end_q;
      end
      JOB_TICK_PAD: begin
        res_kind    = pru_pkg::KIND_PAD;
        res_row_end = job_end_q;
      end
      default: ;
    endcase
  end

  assign job_done = job_valid_q && out_load && res_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      job_cnt_q   <= '0;
    end else if (job_load) begin
      job_valid_q <= 1'b1;
      job_cnt_q   <= '0;
    end else if (job_done) begin
      job_valid_q <= 1'b0;
      job_cnt_q   <= '0;
    end else if (job_valid_q && out_load) begin
      job_cnt_q <= cnt_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load) begin
      job_type_q     <= job_type_d;
      job_rgb_q      <= in_rgb;
      job_s_q        <= s_eff;
      job_pad_q      <= pad;
      job_row_done_q <= row_done;
      job_end_q      <= job_end_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= job_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && job_valid_q) begin
      out_kind_q    <= res_kind;
      out_rgb_q     <= res_rgb;
      out_row_end_q <= res_row_end;
      out_last_q    <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign out_red_o   = out_rgb_q[3*pru_pkg::COLOR_W-1:2*pru_pkg::COLOR_W];
  assign out_green_o = out_rgb_q[2*pru_pkg::COLOR_W-1:pru_pkg::COLOR_W];
  assign out_blue_o  = out_rgb_q[pru_pkg::COLOR_W-1:0];
  assign row_end_o   = out_row_end_q;
  assign last_o      = out_last_q;

  // ---------------------------------------------------------------- checks
  a_reject_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_push && busy |=> job_valid_q && (job_type_q == JOB_REJECT))
    else $error("push during repeats not rejected");

  a_fill_idle_while_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (fill_col_q == '0))
    else $error("fill column moved while rows are owed");

  a_copy_only_while_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (copy_cnt_q != '0) || (pad_cnt_q != '0) |-> busy)
    else $error("drain counters active with no rows owed");

  a_multi_only_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q && (job_cnt_q != '0) |-> (job_type_q == JOB_PUSH))
    else $error("multi-result job that is not a push");

  a_read_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> !job_valid_q || job_done)
    else $error("store read while a tick result is still pending");

endmodule

>>> tb/sv/tb_pixel_replication_upscaler_top.sv
// Testbench for pixel_replication_upscaler_top: directed and random pushes and ticks,
// checked against a cycle-free predictor of the replicated rows and pad bytes.
// Depends on pru_pkg and the upscaler RTL only.
module tb_pixel_replication_upscaler_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned STORE_DEPTH  = 4096;
  localparam int unsigned SCALE_LIMIT  = 16;
  localparam int unsigned WIDE_COLS    = 40;
  localparam int unsigned ROUND_ITEMS  = 35;

  typedef struct packed {
    pru_pkg::kind_e kind;
    logic [7:0]     red;
    logic [7:0]     green;
    logic [7:0]     blue;
    logic           row_end;
    logic           last;
  } pixel_result_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic                           func_i;
  logic [pru_pkg::COLOR_W-1:0]    red_i;
  logic [pru_pkg::COLOR_W-1:0]    green_i;
  logic [pru_pkg::COLOR_W-1:0]    blue_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic [1:0]                     kind_o;
  logic [pru_pkg::COLOR_W-1:0]    out_red_o;
  logic [pru_pkg::COLOR_W-1:0]    out_green_o;
  logic [pru_pkg::COLOR_W-1:0]    out_blue_o;
  logic                           row_end_o;
  logic                           last_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic                           cfg_index_i;
  logic [pru_pkg::CFG_DATA_W-1:0] cfg_data_i;

  // Predictor state
  logic [pru_pkg::RGB_W-1:0]      line_mem [STORE_DEPTH];
  logic [11:0]                    fill_col;
  logic [pru_pkg::ROWS_W-1:0]     rows_owed;
  logic [pru_pkg::WIDTH_W-1:0]    drain_col;
  logic [pru_pkg::COPY_W-1:0]     copies;
  logic [pru_pkg::PADC_W-1:0]     pads_sent;
  logic [pru_pkg::SCALE_W-1:0]    cfg_scale;
  logic [pru_pkg::WIDTH_W-1:0]    cfg_width;
  int unsigned                    stored_cols;

  pixel_result_t         owed_results_q[$];
  pixel_result_t         want;
  int unsigned           fail_count;
  int unsigned           cycle_count;
  int unsigned           idle_pct;
  int unsigned           stall_pct;
  int unsigned           hold_left;

  pixel_replication_upscaler_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .row_end_o   (row_end_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: a long hold-off takes priority over random stalls
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic int unsigned active_scale();
    if (cfg_scale == 0) return 1;
    if (cfg_scale > SCALE_LIMIT) return SCALE_LIMIT;
    return cfg_scale;
  endfunction

  function automatic int unsigned active_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > STORE_DEPTH) return STORE_DEPTH;
    return cfg_width;
  endfunction

  function automatic int unsigned row_pad();
    int unsigned bytes;
    bytes = 3 * active_width() * active_scale();
    return (4 - (bytes % 4)) % 4;
  endfunction

  task automatic expect_result(pru_pkg::kind_e kind, logic [pru_pkg::RGB_W-1:0] rgb,
                               logic row_end);
    pixel_result_t res;
    res.kind    = kind;
    res.red     = rgb[23:16];
    res.green   = rgb[15:8];
    res.blue    = rgb[7:0];
    res.row_end = row_end;
    res.last    = 1'b0;
    owed_results_q.push_back(res);
  endtask

  task automatic finish_row();
    drain_col = '0;
    copies    = '0;
    pads_sent = '0;
    if (rows_owed != 0) rows_owed = rows_owed - 1;
  endtask

  // Work out the results of one accepted request and advance the predicted state
  task automatic predict_upscale(pru_pkg::func_e func, logic [pru_pkg::RGB_W-1:0] rgb);
    int unsigned   s;
    int unsigned   w;
    int unsigned   pad;
    int unsigned   col;
    int unsigned   first;
    int unsigned   i;
    logic          row_done;
    logic          ends;
    logic [pru_pkg::RGB_W-1:0] pix;
    pixel_result_t tail;
    s     = active_scale();
    w     = active_width();
    pad   = row_pad();
    first = owed_results_q.size();
    if (func == pru_pkg::FUNC_PUSH) begin
      if (rows_owed != 0) begin
        expect_result(pru_pkg::KIND_REJECT, '0, 1'b0);
      end else begin
        col      = fill_col;
        row_done = (col + 1 >= w);
        line_mem[col] = rgb;
        if (col + 1 > stored_cols) stored_cols = col + 1;
        for (i = 0; i < s; i++) begin
          expect_result(pru_pkg::KIND_PIXEL, rgb, row_done && pad == 0 && i + 1 == s);
        end
        if (row_done) begin
          for (i = 0; i < pad; i++) begin
            expect_result(pru_pkg::KIND_PAD, '0, i + 1 == pad);
          end
          fill_col  = '0;
          rows_owed = pru_pkg::ROWS_W'(s - 1);
          drain_col = '0;
          copies    = '0;
          pads_sent = '0;
        end else begin
          fill_col = 12'(col + 1);
        end
      end
    end else if (rows_owed != 0) begin
      if (drain_col < w) begin
        col  = drain_col;
        pix  = line_mem[col];
        ends = 1'b0;
        if (copies + 1 >= s) begin
          copies    = '0;
          drain_col = pru_pkg::WIDTH_W'(col + 1);
          ends      = (drain_col >= w) && (pad == 0);
        end else begin
          copies = copies + 1;
        end
        expect_result(pru_pkg::KIND_PIXEL, pix, ends);
        if (ends) finish_row();
      end else begin
        ends = (pads_sent + 1 >= pad);
        expect_result(pru_pkg::KIND_PAD, '0, ends);
        if (ends) finish_row();
        else pads_sent = pads_sent + 1;
      end
    end
    if (owed_results_q.size() > first) begin
      tail = owed_results_q.pop_back();
      tail.last = 1'b1;
      owed_results_q.push_back(tail);
    end
  endtask

  task automatic check_field(string name, logic [pru_pkg::RGB_W-1:0] exp_val,
                             logic [pru_pkg::RGB_W-1:0] got);
    if (got !== exp_val) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_val, got);
      fail_count = fail_count + 1;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_results_q.size() == 0) begin
        $error("result with nothing owed: kind %0d rgb %0h%0h%0h", kind_o, out_red_o,
               out_green_o, out_blue_o);
        fail_count = fail_count + 1;
      end else begin
        want = owed_results_q.pop_front();
        check_field("kind", pru_pkg::RGB_W'(want.kind), pru_pkg::RGB_W'(kind_o));
        check_field("out_red", pru_pkg::RGB_W'(want.red), pru_pkg::RGB_W'(out_red_o));
        check_field("out_green", pru_pkg::RGB_W'(want.green), pru_pkg::RGB_W'(out_green_o));
        check_field("out_blue", pru_pkg::RGB_W'(want.blue), pru_pkg::RGB_W'(out_blue_o));
        check_field("row_end", pru_pkg::RGB_W'(want.row_end), pru_pkg::RGB_W'(row_end_o));
        check_field("last", pru_pkg::RGB_W'(want.last), pru_pkg::RGB_W'(last_o));
      end
    end
  end

  task automatic send_request(pru_pkg::func_e func, logic [pru_pkg::RGB_W-1:0] rgb);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= func;
    red_i      <= rgb[23:16];
    green_i    <= rgb[15:8];
    blue_i     <= rgb[7:0];
    do @(posedge clk_i); while (in_stall_o);
    predict_upscale(func, rgb);
  endtask

  // Drop valid and wait until every owed result has come out
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (owed_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(pru_pkg::cfg_reg_e index,
                                logic [pru_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == pru_pkg::CFG_SCALE) cfg_scale = data[pru_pkg::SCALE_W-1:0];
    else cfg_width = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_rows();
    while (rows_owed != 0) send_request(pru_pkg::FUNC_TICK, pru_pkg::RGB_W'($urandom));
  endtask

  task automatic test_defaults();
    idle_pct  = 0;
    stall_pct = 0;
    send_request(pru_pkg::FUNC_PUSH, 24'h000000);
    send_request(pru_pkg::FUNC_PUSH, 24'hFFFFFF);
    send_request(pru_pkg::FUNC_TICK, 24'hFFFFFF);
    send_request(pru_pkg::FUNC_TICK, 24'h000000);
    settle_block();
  endtask

  task automatic test_reject_and_pad();
    write_register(pru_pkg::CFG_SCALE, 13'd2);
    write_register(pru_pkg::CFG_SOURCE_WIDTH, 13'd3);
    send_request(pru_pkg::FUNC_PUSH, 24'hFF0000);
    send_request(pru_pkg::FUNC_PUSH, 24'h00FF00);
    send_request(pru_pkg::FUNC_PUSH, 24'h0000FF);
    send_request(pru_pkg::FUNC_PUSH, 24'h123456);
    drain_rows();
    send_request(pru_pkg::FUNC_TICK, 24'h0);
    settle_block();
  endtask

  task automatic test_config_midrow();
    // Copy count already past a smaller scale
    write_register(pru_pkg::CFG_SCALE, 13'd4);
    write_register(pru_pkg::CFG_SOURCE_WIDTH, 13'd1);
    send_request(pru_pkg::FUNC_PUSH, 24'hAA5533);
    send_request(pru_pkg::FUNC_TICK, 24'h0);
    send_request(pru_pkg::FUNC_TICK, 24'h0);
    settle_block();
    write_register(pru_pkg::CFG_SCALE, 13'd2);
    drain_rows();
    settle_block();
    // Pixels done, pad now zero: one closing pad byte
    send_request(pru_pkg::FUNC_PUSH, 24'h5A5A5A);
    send_request(pru_pkg::FUNC_TICK, 24'h0);
    send_request(pru_pkg::FUNC_TICK, 24'h0);
    settle_block();
    write_register(pru_pkg::CFG_SCALE, 13'd4);
    drain_rows();
    settle_block();
    // Drain column beyond a narrower width
    write_register(pru_pkg::CFG_SCALE, 13'd2);
    write_register(pru_pkg::CFG_SOURCE_WIDTH, 13'd4);
    repeat (4) send_request(pru_pkg::FUNC_PUSH, pru_pkg::RGB_W'($urandom));
    repeat (6) send_request(pru_pkg::FUNC_TICK, 24'h0);
    settle_block();
    write_register(pru_pkg::CFG_SOURCE_WIDTH, 13'd2);
    drain_rows();
    settle_block();
  endtask

  task automatic test_extremes();
    idle_pct  = 0;
    stall_pct = 0;
    // Scale above the limit: sixteen copies, fifteen owed rows, drained at scale one
    write_register(pru_pkg::CFG_SCALE, 13'd31);
    write_register(pru_pkg::CFG_SOURCE_WIDTH, 13'd0);
    send_request(pru_pkg::FUNC_PUSH, pru_pkg::RGB_W'($urandom));
    send_request(pru_pkg::FUNC_PUSH, pru_pkg::RGB_W'($urandom));
    settle_block();
    write_register(pru_pkg::CFG_SCALE, 13'd1);
    drain_rows();
    settle_block();
    write_register(pru_pkg::CFG_SCALE, 13'd15);
    write_register(pru_pkg::CFG_SOURCE_WIDTH, 13'd1);
    send_request(pru_pkg::FUNC_PUSH, pru_pkg::RGB_W'($urandom));
    settle_block();
    write_register(pru_pkg::CFG_SCALE, 13'd1);
    drain_rows();
    settle_block();
    // Scale zero and a width beyond the store, then a narrower width ends the row
    write_register(pru_pkg::CFG_SCALE, 13'd0);
    write_register(pru_pkg::CFG_SOURCE_WIDTH, 13'h1FFF);
    repeat (WIDE_COLS) send_request(pru_pkg::FUNC_PUSH, pru_pkg::RGB_W'($urandom));
    settle_block();
    write_register(pru_pkg::CFG_SOURCE_WIDTH, pru_pkg::CFG_DATA_W'(WIDE_COLS));
    send_request(pru_pkg::FUNC_PUSH, pru_pkg::RGB_W'($urandom));
    send_request(pru_pkg::FUNC_TICK, 24'h0);
    settle_block();
  endtask

  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    write_register(pru_pkg::CFG_SCALE, 13'd4);
    write_register(pru_pkg::CFG_SOURCE_WIDTH, 13'd4);
    hold_left = 300;
    repeat (4) send_request(pru_pkg::FUNC_PUSH, pru_pkg::RGB_W'($urandom));
    send_request(pru_pkg::FUNC_PUSH, pru_pkg::RGB_W'($urandom));
    drain_rows();
    settle_block();
  endtask

  task automatic pick_random_setting();
    logic [pru_pkg::SCALE_W-1:0] sc;
    logic [pru_pkg::WIDTH_W-1:0] wd;
    int unsigned                 eff_s;
    sc = ($urandom_range(3) == 0) ? pru_pkg::SCALE_W'($urandom_range(31))
                                  : pru_pkg::SCALE_W'($urandom_range(1, 4));
    eff_s = (sc == 0) ? 1 : ((sc > SCALE_LIMIT) ? SCALE_LIMIT : sc);
    wd = (eff_s > 4) ? pru_pkg::WIDTH_W'($urandom_range(3))
                     : pru_pkg::WIDTH_W'($urandom_range(12));
    // Keep rows still owed inside the written part of the store
    if (rows_owed != 0 && wd > stored_cols) wd = pru_pkg::WIDTH_W'(stored_cols);
    write_register(pru_pkg::CFG_SCALE, pru_pkg::CFG_DATA_W'(sc));
    write_register(pru_pkg::CFG_SOURCE_WIDTH, wd);
  endtask

  task automatic random_traffic(int unsigned count);
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      if (rows_owed == 0) begin
        if ($urandom_range(99) < 88) begin
          send_request(pru_pkg::FUNC_PUSH, pru_pkg::RGB_W'($urandom));
          sent++;
        end else begin
          send_request(pru_pkg::FUNC_TICK, pru_pkg::RGB_W'($urandom));
        end
      end else begin
        if ($urandom_range(99) < 92) begin
          send_request(pru_pkg::FUNC_TICK, pru_pkg::RGB_W'($urandom));
        end else begin
          send_request(pru_pkg::FUNC_PUSH, pru_pkg::RGB_W'($urandom));
        end
        sent++;
      end
    end
  endtask

  task automatic test_random();
    int unsigned mode;
    int unsigned k;
    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      for (k = 0; k < 2; k++) begin
        settle_block();
        pick_random_setting();
        random_traffic(ROUND_ITEMS);
      end
    end
    settle_block();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    func_i      = 1'b0;
    red_i       = '0;
    green_i     = '0;
    blue_i      = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = 1'b0;
    cfg_data_i  = '0;
    fill_col    = '0;
    rows_owed   = '0;
    drain_col   = '0;
    copies      = '0;
    pads_sent   = '0;
    cfg_scale   = 5'd1;
    cfg_width   = 13'd1;
    stored_cols = 0;
    fail_count  = 0;
    cycle_count = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_left   = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_defaults();
    test_reject_and_pad();
    test_config_midrow();
    test_extremes();
    test_backpressure();
    test_random();

    settle_block();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
